### rtl/bfh_pkg.sv
package bfh_pkg;

    localparam int KEY_W     = 64;
    localparam int FILL_W    = 13;
    localparam int SIZE_W    = 4;
    localparam int SIZE_MIN  = 6;
    localparam int LANES     = 4;
    localparam int ROW_SHIFT = 6;
    localparam int ROW_BITS  = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd12;

    localparam logic [KEY_W-1:0] HASH_SUB = 64'd4484849178131;
    localparam logic [KEY_W-1:0] HASH_MUL = 64'd5159830179831;
    localparam logic [KEY_W-1:0] HASH_OFF = 64'd3511938889975819;

    localparam int MIX_SHR = 37;
    localparam int MIX_SHL = 11;

    localparam logic [5:0] ROT_AMT [LANES] = '{6'd0, 6'd17, 6'd23, 6'd51};

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [KEY_W-1:0] rotr64(input logic [KEY_W-1:0] v,
                                                input logic [5:0] r);
        logic [2*KEY_W-1:0] d;
        d = {v, v} >> r;
        return d[KEY_W-1:0];
    endfunction

endpackage

### rtl/bfh_in_if.sv
interface bfh_in_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [bfh_pkg::KEY_W-1:0]  key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

### rtl/bfh_out_if.sv
interface bfh_out_if;
    logic                       valid;
    logic                       ready;
    logic                       present;
    logic [bfh_pkg::FILL_W-1:0] fill_count;

    modport source (output valid, output present, output fill_count, input ready);
    modport sink   (input valid, input present, input fill_count, output ready);
endinterface

### rtl/bloom_filter_four_hash_core.sv
// channel   dir  words                     handshake
// i_req     in   operation, key            valid/ready
// o_rsp     out  present, fill_count       valid/ready
// i_cfg     in   size_log2 (i_cfg_data)    i_cfg_we, no stall
//
// Front hashes each lane through subtract, multiply and mix states, then pushes the word and returns to accept.
// Back works through each word in order: pop, a read and a compare-write per lane, result load.
// The front accepts a new word only after pushing the last one; the back may still be working on it.
// Reset and each size write start a clear pass over TABLE_BITS_MAX/64 table rows; i_req stalls.
// A two-word queue parts front and back; a held result stalls the front once the queue fills.
module bloom_filter_four_hash_core #(
    parameter int TABLE_BITS_MAX = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bfh_in_if.sink                       i_req,
    bfh_out_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [bfh_pkg::SIZE_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_BITS_MAX);
    localparam int JOB_W  = bfh_pkg::LANES * ADDR_W + 1;
    localparam logic [4:0] S_MAX = 5'(ADDR_W);
    localparam logic [4:0] S_MIN = 5'(bfh_pkg::SIZE_MIN);

    logic [bfh_pkg::SIZE_W-1:0] r_size;
    logic [4:0]                 w_s;
    logic [ADDR_W-1:0]          w_mask;
    logic                       w_busy;
    logic                       w_push;
    logic                       w_pop;
    logic [JOB_W-1:0]           w_job_in;
    logic [JOB_W-1:0]           w_job_out;
    bfh_pkg::t_q_stat           w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= bfh_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_comb begin
        w_s = {1'b0, r_size};
        if (w_s < S_MIN) begin
            w_s = S_MIN;
        end else if (w_s > S_MAX) begin
            w_s = S_MAX;
        end
        w_mask = ~({ADDR_W{1'b1}} << w_s);
    end

    bfh_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_mask   (w_mask),
        .i_hold   (w_busy),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    bfh_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_q_stat)
    );

    bfh_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .o_busy   (w_busy),
        .i_q_stat (w_q_stat),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_rsp    (o_rsp)
    );

endmodule

### rtl/bfh_ram.sv
module bfh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bfh_queue.sv
module bfh_queue #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output bfh_pkg::t_q_stat o_stat
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

`ifndef SYNTHESIS
    a_q_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill level");
`endif

endmodule

### rtl/bfh_front.sv
module bfh_front #(
    parameter int ADDR_W = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bfh_in_if.sink                             i_req,
    input  logic [ADDR_W-1:0]                  i_mask,
    input  logic                               i_hold,
    input  bfh_pkg::t_q_stat                   i_q_stat,
    output logic                               o_push,
    output logic [bfh_pkg::LANES*ADDR_W:0]     o_job
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SUB  = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_MIX  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [1:0]                  r_lane;
    logic                        r_op;
    logic [bfh_pkg::KEY_W-1:0]   r_key;
    logic [bfh_pkg::KEY_W-1:0]   r_v;
    logic [bfh_pkg::KEY_W-1:0]   r_p0;
    logic [31:0]                 r_p1;
    logic [31:0]                 r_p2;
    logic [ADDR_W-1:0]           r_pos [bfh_pkg::LANES];

    logic                        w_accept;
    logic [bfh_pkg::KEY_W-1:0]   w_rot;
    logic [bfh_pkg::KEY_W-1:0]   w_h;
    logic [bfh_pkg::KEY_W-1:0]   w_mix;

    assign i_req.ready = (r_state == F_IDLE) && !i_hold;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_rot = bfh_pkg::rotr64(r_key, bfh_pkg::ROT_AMT[r_lane]);
    assign w_h   = r_p0 + {r_p1 + r_p2, 32'h0} - bfh_pkg::HASH_OFF;
    assign w_mix = w_h ^ (w_h >> bfh_pkg::MIX_SHR) ^ (w_h << bfh_pkg::MIX_SHL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_SUB;
                end
            end
            F_SUB:  n_state = F_MUL;
            F_MUL:  n_state = F_MIX;
            F_MIX: begin
                n_state = (r_lane == 2'd3) ? F_PUSH : F_SUB;
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_lane  <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_op   <= i_req.operation;
                        r_key  <= i_req.key;
                        r_lane <= 2'd0;
                    end
                end
                F_SUB: begin
                    r_v <= w_rot - bfh_pkg::HASH_SUB;
                end
                F_MUL: begin
                    r_p0 <= r_v[31:0] * bfh_pkg::HASH_MUL[31:0];
                    r_p1 <= r_v[31:0] * bfh_pkg::HASH_MUL[63:32];
                    r_p2 <= r_v[63:32] * bfh_pkg::HASH_MUL[31:0];
                end
                F_MIX: begin
                    r_pos[r_lane] <= w_mix[ADDR_W-1:0] & i_mask;
                    r_lane        <= r_lane + 2'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_job  = {r_op, r_pos[3], r_pos[2], r_pos[1], r_pos[0]};

`ifndef SYNTHESIS
    a_fr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == F_SUB) && (r_lane == 2'd0))
        else $error("hash sequence did not start at first lane");
    a_fr_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_lane == 2'd0))
        else $error("word pushed before all lanes hashed");
`endif

endmodule

### rtl/bfh_back.sv
module bfh_back #(
    parameter int ADDR_W = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    output logic                               o_busy,
    input  bfh_pkg::t_q_stat                   i_q_stat,
    input  logic [bfh_pkg::LANES*ADDR_W:0]     i_job,
    output logic                               o_pop,
    bfh_out_if.source                          o_rsp
);

    localparam int ROWS   = 1 << (ADDR_W - bfh_pkg::ROW_SHIFT);
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_CHK  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [1:0]                        r_lane;
    logic [bfh_pkg::LANES*ADDR_W:0]    r_job;
    logic                              r_all;
    logic [bfh_pkg::FILL_W-1:0]        r_count;
    logic                              r_clr;
    logic [ROW_AW-1:0]                 r_clr_row;
    logic                              r_ovalid;
    logic                              r_present;
    logic [bfh_pkg::FILL_W-1:0]        r_fill;

    logic [ADDR_W-1:0]                 w_pos [bfh_pkg::LANES];
    logic [ADDR_W-1:0]                 w_cur;
    logic [ROW_AW-1:0]                 w_row;
    logic [bfh_pkg::ROW_SHIFT-1:0]     w_bidx;
    logic [bfh_pkg::ROW_BITS-1:0]      w_rdata;
    logic                              w_bit;
    logic                              w_set;
    logic                              w_load;
    logic                              w_we;
    logic [ROW_AW-1:0]                 w_waddr;
    logic [bfh_pkg::ROW_BITS-1:0]      w_wdata;

    always_comb begin
        for (int i = 0; i < bfh_pkg::LANES; i++) begin
            w_pos[i] = r_job[i*ADDR_W +: ADDR_W];
        end
    end

    assign w_cur  = w_pos[r_lane];
    assign w_row  = ROW_AW'(w_cur >> bfh_pkg::ROW_SHIFT);
    assign w_bidx = w_cur[bfh_pkg::ROW_SHIFT-1:0];
    assign w_bit  = w_rdata[w_bidx];
    assign w_set  = (r_state == B_CHK) && r_job[bfh_pkg::LANES*ADDR_W] && !w_bit;
    assign w_load = (r_state == B_OUT) && (!r_ovalid || o_rsp.ready);

    assign w_we    = r_clr || w_set;
    assign w_waddr = r_clr ? r_clr_row : w_row;
    assign w_wdata = r_clr ? '0
                   : (w_rdata | ({{(bfh_pkg::ROW_BITS-1){1'b0}}, 1'b1} << w_bidx));

    bfh_ram #(
        .WIDTH (bfh_pkg::ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == B_RD),
        .i_raddr (w_row),
        .o_rdata (w_rdata)
    );

    assign o_pop  = (r_state == B_IDLE) && !r_clr && !i_q_stat.empty;
    assign o_busy = r_clr;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_state = B_RD;
                end
            end
            B_RD:  n_state = B_CHK;
            B_CHK: n_state = (r_lane == 2'd3) ? B_OUT : B_RD;
            B_OUT: begin
                if (w_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_lane    <= 2'd0;
            r_count   <= '0;
            r_clr     <= 1'b1;
            r_clr_row <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_job  <= i_job;
                r_lane <= 2'd0;
                r_all  <= 1'b1;
            end
            if (r_state == B_CHK) begin
                r_lane <= r_lane + 2'd1;
                if (!w_bit) begin
                    r_all <= 1'b0;
                end
            end
            if (i_clear) begin
                r_clr     <= 1'b1;
                r_clr_row <= '0;
                r_count   <= '0;
            end else begin
                if (r_clr) begin
                    r_clr_row <= r_clr_row + 1'b1;
                    if (r_clr_row == ROW_LAST) begin
                        r_clr <= 1'b0;
                    end
                end
                if (w_set) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_load) begin
                r_ovalid  <= 1'b1;
                r_present <= r_all;
                r_fill    <= r_count;
            end
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.present    = r_present;
    assign o_rsp.fill_count = r_fill;

`ifndef SYNTHESIS
    a_bk_noclr_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_pop)
        else $error("word taken from queue during clear pass");
    a_bk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_clear |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1))
        else $error("fill count moved by more than one");
    a_bk_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT) |-> (r_lane == 2'd0))
        else $error("result formed before all four lanes checked");
`endif

endmodule
